// ===== rtl/stm_pkg.sv =====
// Shared types, character codes and byte classes for the script text minifier.
// No dependencies; imported by every module of the block.
package stm_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_LPAR  = 8'd40;
  localparam logic [7:0] CH_RPAR  = 8'd41;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_LBRK  = 8'd91;
  localparam logic [7:0] CH_BSL   = 8'd92;
  localparam logic [7:0] CH_RBRK  = 8'd93;
  localparam logic [7:0] CH_USCORE = 8'd95;
  localparam logic [7:0] CH_BTICK = 8'd96;
  localparam logic [7:0] CH_LBRC  = 8'd123;
  localparam logic [7:0] CH_RBRC  = 8'd125;
  localparam logic [7:0] WORD_LIMIT = 8'd126;

  // Result buffer: each entry holds the one or two results of one byte
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_LINE,
    MODE_BLOCK,
    MODE_QUOTE
  } stm_mode_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } stm_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;
    logic       bad_comment;
  } stm_out_t;

  // Results of one byte: cnt is 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    stm_out_t   first;
    stm_out_t   second;
  } stm_pair_t;

  function automatic logic word_like(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) ||
           (c >= 8'd48 && c <= 8'd57) || c == CH_USCORE || c == CH_DOLLAR ||
           c == CH_BSL || c > WORD_LIMIT;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic quote_byte(input logic [7:0] c);
    return c == CH_DQ || c == CH_SQ || c == CH_BTICK;
  endfunction

  function automatic logic space_side(input logic [7:0] c);
    return word_like(c) || c == CH_SQ || c == CH_SLASH || c == CH_PLUS ||
           c == CH_MINUS;
  endfunction

  function automatic logic nl_before(input logic [7:0] c);
    return word_like(c) || c == CH_SQ || c == CH_DQ || c == CH_RBRC ||
           c == CH_RBRK || c == CH_RPAR || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic nl_after(input logic [7:0] c);
    return word_like(c) || c == CH_SQ || c == CH_LBRC || c == CH_LBRK ||
           c == CH_LPAR || c == CH_PLUS || c == CH_MINUS;
  endfunction

endpackage

// ===== rtl/stm_core.sv =====
// Scanner state and per-byte minify decision: one byte in, up to two results out.
// Depends on stm_pkg.
module stm_core import stm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  stm_in_t   item,
  output stm_pair_t results
);

  stm_mode_t  mode, mode_next, mode_s;
  logic [7:0] held_char, held_char_next, held_s;
  logic       have_held, have_held_next, hh_s;
  logic [7:0] prior_char, prior_char_next, prior_s;
  logic [7:0] quote_kind, quote_kind_next, qk_s;
  logic       star_seen, star_seen_next, star_s;

  logic [7:0] c;
  logic       last;
  logic [7:0] em0, em1;
  logic [1:0] n;
  logic       marker;
  logic       bad;

  assign c    = item.in_char;
  assign last = item.in_last;

  // Next state
  always_comb begin
    mode_s  = mode;
    held_s  = held_char;
    hh_s    = have_held;
    prior_s = prior_char;
    qk_s    = quote_kind;
    star_s  = star_seen;
    unique case (mode)
      MODE_LINE: begin
        if (c == CH_NL) begin
          mode_s  = MODE_NORMAL;
          prior_s = CH_NL;
          hh_s    = 1'b0;
        end
      end
      MODE_BLOCK: begin
        if (star_seen && c == CH_SLASH) begin
          mode_s  = MODE_NORMAL;
          prior_s = CH_NL;
          hh_s    = 1'b0;
          star_s  = 1'b0;
        end else begin
          star_s = (c == CH_STAR);
        end
      end
      MODE_QUOTE: begin
        if (c == quote_kind) begin
          mode_s  = MODE_NORMAL;
          prior_s = c;
          hh_s    = 1'b0;
        end
      end
      MODE_NORMAL: begin
        if (!have_held) begin
          held_s = c;
          hh_s   = 1'b1;
        end else if (held_char == CH_CR) begin
          prior_s = held_char;
          held_s  = c;
        end else if (held_char == CH_SLASH) begin
          if (c == CH_SLASH) begin
            mode_s = MODE_LINE;
            hh_s   = 1'b0;
          end else if (c == CH_STAR) begin
            mode_s = MODE_BLOCK;
            star_s = 1'b0;
            hh_s   = 1'b0;
          end else begin
            prior_s = held_char;
            held_s  = c;
          end
        end else if (blank(held_char)) begin
          // hold the first blank of a run until a non-blank shows up
          if (!blank(c)) begin
            prior_s = held_char;
            held_s  = c;
          end
        end else if (held_char == CH_NL) begin
          if (c != CH_NL && !blank(c)) begin
            prior_s = CH_NL;
            held_s  = c;
          end
        end else if (quote_byte(held_char)) begin
          hh_s = 1'b0;
          if (c == held_char) begin
            prior_s = c;
          end else begin
            mode_s = MODE_QUOTE;
            qk_s   = held_char;
          end
        end else begin
          prior_s = held_char;
          held_s  = c;
        end
      end
    endcase

    // end of stream: return everything to its reset values
    if (last) begin
      mode_next       = MODE_NORMAL;
      held_char_next  = '0;
      have_held_next  = 1'b0;
      prior_char_next = CH_NL;
      quote_kind_next = '0;
      star_seen_next  = 1'b0;
    end else begin
      mode_next       = mode_s;
      held_char_next  = held_s;
      have_held_next  = hh_s;
      prior_char_next = prior_s;
      quote_kind_next = qk_s;
      star_seen_next  = star_s;
    end
  end

  // Outputs
  always_comb begin
    em0    = '0;
    em1    = '0;
    n      = 2'd0;
    marker = 1'b0;
    unique case (mode)
      MODE_LINE, MODE_BLOCK: begin
      end
      MODE_QUOTE: begin
        em0 = c;
        n   = 2'd1;
      end
      MODE_NORMAL: begin
        if (have_held) begin
          if (held_char == CH_CR) begin
            em0 = CH_NL;
            n   = 2'd1;
          end else if (held_char == CH_SLASH) begin
            if (c != CH_SLASH && c != CH_STAR) begin
              em0 = held_char;
              n   = 2'd1;
            end
          end else if (blank(held_char)) begin
            if (!blank(c) && space_side(prior_char) && space_side(c)) begin
              em0 = CH_SP;
              n   = 2'd1;
            end
          end else if (held_char == CH_NL) begin
            if (c != CH_NL && !blank(c) && nl_before(prior_char) && nl_after(c)) begin
              em0 = CH_NL;
              n   = 2'd1;
            end
          end else if (quote_byte(held_char)) begin
            em0 = held_char;
            em1 = c;
            n   = 2'd2;
          end else begin
            em0 = held_char;
            n   = 2'd1;
          end
        end
      end
    endcase

    // flush a held byte at stream end unless it is whitespace
    if (last && mode_s == MODE_NORMAL && hh_s && !blank(held_s) &&
        held_s != CH_NL && held_s != CH_CR) begin
      if (n == 2'd0) begin
        em0 = held_s;
        n   = 2'd1;
      end else if (n == 2'd1) begin
        em1 = held_s;
        n   = 2'd2;
      end
    end

    if (last && n == 2'd0) begin
      marker = 1'b1;
      n      = 2'd1;
    end
  end

  assign bad = last && (mode_s == MODE_BLOCK);

  assign results.cnt                  = n;
  assign results.first.out_char       = em0;
  assign results.first.has_char       = !marker;
  assign results.first.out_last       = last && (n == 2'd1);
  assign results.first.bad_comment    = bad && (n == 2'd1);
  assign results.second.out_char      = em1;
  assign results.second.has_char      = 1'b1;
  assign results.second.out_last      = last;
  assign results.second.bad_comment   = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      held_char  <= '0;
      have_held  <= 1'b0;
      prior_char <= CH_NL;
      quote_kind <= '0;
      star_seen  <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      held_char  <= held_char_next;
      have_held  <= have_held_next;
      prior_char <= prior_char_next;
      quote_kind <= quote_kind_next;
      star_seen  <= star_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step && item.in_last |=> mode == MODE_NORMAL && !have_held && prior_char == CH_NL)
    else $error("scanner state not cleared after final byte");

  a_quote_kind: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_QUOTE |-> quote_byte(quote_kind))
    else $error("quote mode without an opening quote byte");

  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    step && item.in_last |-> results.cnt != 2'd0)
    else $error("final byte produced no result");
`endif

endmodule

// ===== rtl/stm_out_fifo.sv =====
// Result buffer: one entry per byte that gives results, holding its one or two results,
// drained one result per transfer. Depends on stm_pkg.
module stm_out_fifo import stm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  stm_pair_t push_data,
  output logic      room,
  output logic      valid,
  input  logic      stall,
  output stm_out_t  data
);

  stm_pair_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count, count_next;
  logic              sub;
  logic              pop_item, pop_entry;

  assign valid     = (count != '0);
  assign room      = (count != CNT_W'(FIFO_DEPTH));
  assign data      = sub ? mem[rptr].second : mem[rptr].first;
  assign pop_item  = valid && !stall;
  assign pop_entry = pop_item && (sub || mem[rptr].cnt == 2'd1);

  always_comb begin
    count_next = count;
    if (push && !pop_entry) begin
      count_next = count + CNT_W'(1);
    end else if (!push && pop_entry) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      sub   <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop_entry) begin
        rptr <= rptr + PTR_W'(1);
        sub  <= 1'b0;
      end else if (pop_item) begin
        sub  <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(FIFO_DEPTH) || pop_entry)
    else $error("result buffer overflow");

  a_entry_size: assert property (@(posedge clk) disable iff (rst)
    push |-> push_data.cnt == 2'd1 || push_data.cnt == 2'd2)
    else $error("empty or oversized entry pushed");

  a_sub_only_pairs: assert property (@(posedge clk) disable iff (rst)
    sub |-> valid && mem[rptr].cnt == 2'd2)
    else $error("second result selected from a single-result entry");
`endif

endmodule

// ===== rtl/script_text_minifier.sv =====
// Top level of the script text minifier: request register, scanner and result buffer.
// Depends on stm_pkg, stm_core and stm_out_fifo.
//
// Usage:
//   Request channel (src_valid / src_stall / src_data) takes one source byte per
//   transfer, with in_last set on the final byte of a script. Result channel
//   (res_valid / res_stall / res_data) gives minified bytes one per transfer;
//   has_char low marks an end-only result, out_last flags the final result of
//   a script and bad_comment reports an unterminated block comment there.
//   An accepted byte waits in the request register until the result buffer has
//   room, then is scanned and its results are registered in a buffer entry.
//   Throughput: one byte per cycle while src_stall is low. A byte gives zero, one or
//   two results, and the result side moves one result per cycle while res_stall is
//   low, so bytes that give two results (quotes opening, a held byte flushed at the
//   end) drain at half that rate. The result buffer holds four bytes' worth of results;
//   when it is full and a byte waits in the request register, src_stall rises until
//   res_stall lets results drain. src_stall comes from registers only.
//   Reset: scanner returns to normal mode with nothing held, the result buffer
//   empties. The scanner also resets itself after every final byte.
module script_text_minifier import stm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  stm_in_t  src_data,
  output logic     res_valid,
  input  logic     res_stall,
  output stm_out_t res_data
);

  stm_in_t   req;
  logic      req_valid;
  logic      advance;
  logic      room;
  stm_pair_t results;

  assign advance   = req_valid && room;
  assign src_stall = req_valid && !room;

  // Hold the request until the scanner can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!src_stall) begin
      req_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      req <= src_data;
    end
  end

  stm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (req),
    .results (results)
  );

  stm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && results.cnt != 2'd0),
    .push_data (results),
    .room      (room),
    .valid     (res_valid),
    .stall     (res_stall),
    .data      (res_data)
  );

endmodule

// ===== verif/script_text_minifier_chk.sv =====
`timescale 1ns / 1ps
// Checker for the script text minifier: watches both channels, predicts the minified
// byte stream and compares each result field by field. Depends on stm_pkg.
module script_text_minifier_chk import stm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  logic     src_stall,
  input  stm_in_t  src_data,
  input  logic     res_valid,
  input  logic     res_stall,
  input  stm_out_t res_data,
  output int       fails = 0,
  output int       waiting = 0
);

  // Scanner copy
  stm_mode_t  scan;
  logic [7:0] held_ch;
  logic       held_ok;
  logic [7:0] prior_ch;
  logic [7:0] quote_ch;
  logic       star_hit;

  stm_out_t minified_q[$];
  stm_out_t step_res[$];
  stm_out_t want;
  int       fail_cnt = 0;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == CH_USCORE || c == CH_DOLLAR || c == CH_BSL || c > WORD_LIMIT;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c == CH_DQ || c == CH_SQ || c == CH_BTICK;
  endfunction

  function automatic logic space_ok(input logic [7:0] c);
    return is_word(c) || c == CH_SQ || c == CH_SLASH || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic nl_left_ok(input logic [7:0] c);
    return is_word(c) || c == CH_SQ || c == CH_DQ || c == CH_RBRC || c == CH_RBRK ||
           c == CH_RPAR || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic nl_right_ok(input logic [7:0] c);
    return is_word(c) || c == CH_SQ || c == CH_LBRC || c == CH_LBRK || c == CH_LPAR ||
           c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic void clear_scan();
    scan     = MODE_NORMAL;
    held_ch  = 8'h00;
    held_ok  = 1'b0;
    prior_ch = CH_NL;
    quote_ch = 8'h00;
    star_hit = 1'b0;
  endfunction

  // At most two bytes come out of one request
  function automatic void put_byte(input logic [7:0] c);
    stm_out_t r;
    r = '0;
    r.out_char = c;
    r.has_char = 1'b1;
    if (step_res.size() < 2) step_res.insert(step_res.size(), r);
  endfunction

  task automatic minify_step(input logic [7:0] c, input logic last);
    stm_out_t tail;
    logic     bad;
    step_res.delete();
    bad = 1'b0;
    case (scan)
      MODE_LINE: if (c == CH_NL) begin
        scan = MODE_NORMAL;
        prior_ch = CH_NL;
        held_ok = 1'b0;
      end
      MODE_BLOCK: if (star_hit && c == CH_SLASH) begin
        scan = MODE_NORMAL;
        prior_ch = CH_NL;
        held_ok = 1'b0;
        star_hit = 1'b0;
      end else begin
        star_hit = (c == CH_STAR);
      end
      MODE_QUOTE: begin
        put_byte(c);
        if (c == quote_ch) begin
          scan = MODE_NORMAL;
          prior_ch = c;
          held_ok = 1'b0;
        end
      end
      default: if (!held_ok) begin
        held_ch = c;
        held_ok = 1'b1;
      end else if (held_ch == CH_CR) begin
        put_byte(CH_NL);
        prior_ch = held_ch;
        held_ch = c;
      end else if (held_ch == CH_SLASH) begin
        if (c == CH_SLASH) begin
          scan = MODE_LINE;
          held_ok = 1'b0;
        end else if (c == CH_STAR) begin
          scan = MODE_BLOCK;
          star_hit = 1'b0;
          held_ok = 1'b0;
        end else begin
          put_byte(held_ch);
          prior_ch = held_ch;
          held_ch = c;
        end
      end else if (is_blank(held_ch)) begin
        // hold the run until a non-blank byte decides the space
        if (!is_blank(c)) begin
          if (space_ok(prior_ch) && space_ok(c)) put_byte(CH_SP);
          prior_ch = held_ch;
          held_ch = c;
        end
      end else if (held_ch == CH_NL) begin
        if (c != CH_NL && !is_blank(c)) begin
          if (nl_left_ok(prior_ch) && nl_right_ok(c)) put_byte(CH_NL);
          prior_ch = CH_NL;
          held_ch = c;
        end
      end else if (is_quote(held_ch)) begin
        put_byte(held_ch);
        put_byte(c);
        held_ok = 1'b0;
        if (c == held_ch) begin
          prior_ch = c;
        end else begin
          scan = MODE_QUOTE;
          quote_ch = held_ch;
        end
      end else begin
        put_byte(held_ch);
        prior_ch = held_ch;
        held_ch = c;
      end
    endcase

    if (last) begin
      // drop trailing whitespace, flush anything else
      if (scan == MODE_NORMAL && held_ok && !is_blank(held_ch) && held_ch != CH_NL &&
          held_ch != CH_CR)
        put_byte(held_ch);
      bad = (scan == MODE_BLOCK);
      clear_scan();
      if (step_res.size() == 0) begin
        tail = '0;
        step_res.insert(step_res.size(), tail);
      end
      tail = step_res.pop_back();
      tail.out_last = 1'b1;
      tail.bad_comment = bad;
      step_res.insert(step_res.size(), tail);
    end
    foreach (step_res[i]) minified_q.insert(minified_q.size(), step_res[i]);
  endtask

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      minified_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (minified_q.size() == 0) begin
          $error("unexpected result: out_char %0d has_char %0d out_last %0d",
                 res_data.out_char, res_data.has_char, res_data.out_last);
          fail_cnt++;
        end else begin
          want = minified_q.pop_front();
          check_field("out_char", want.out_char, res_data.out_char);
          check_field("has_char", want.has_char, res_data.has_char);
          check_field("out_last", want.out_last, res_data.out_last);
          check_field("bad_comment", want.bad_comment, res_data.bad_comment);
        end
      end
      if (src_valid && !src_stall) minify_step(src_data.in_char, src_data.in_last);
    end
    fails   <= fail_cnt;
    waiting <= minified_q.size();
  end

endmodule

// ===== verif/script_text_minifier_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the script text minifier: clock, reset, request and stall stimulus.
// Depends on stm_pkg, script_text_minifier and script_text_minifier_chk.
module script_text_minifier_tb;
  import stm_pkg::*;

  localparam int LIMIT = 600000;
  localparam int RANDOM_BYTES = 400;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  stm_in_t  src_data = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  stm_out_t res_data;

  int   fails;
  int   waiting;
  int   cycles = 0;
  bit   src_calm = 1'b0;
  bit   sink_calm = 1'b0;
  int   stall_left = 0;
  logic [7:0] text_q[$];

  script_text_minifier u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  script_text_minifier_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .fails     (fails),
    .waiting   (waiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("script_text_minifier_tb NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (cycles % 300 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      res_stall <= 1'b0;
      stall_left = sink_calm ? 0 : pick_gap();
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] c, input logic last);
    int      gap;
    stm_in_t req;
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.in_char = c;
    req.in_last = last;
    src_data  <= req;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit closes);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], closes && i == s.len() - 1);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'("a" + $urandom_range(0, 25));
      3:       return 8'("A" + $urandom_range(0, 25));
      4:       return 8'("0" + $urandom_range(0, 9));
      5:       return CH_USCORE;
      6:       return CH_DOLLAR;
      7:       return CH_BSL;
      8:       return 8'($urandom_range(127, 255));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Append one lexical piece of script, sometimes broken or pure noise
  function automatic void add_piece();
    string      punct;
    logic [7:0] q;
    logic [7:0] b;
    punct = ".;,=+-{}[]()<>!&|?:%~#*";
    case ($urandom_range(0, 15))
      0, 1, 2: repeat ($urandom_range(1, 5)) append_byte(word_char());
      3, 4: append_byte(punct[$urandom_range(0, punct.len() - 1)]);
      5: repeat ($urandom_range(1, 4)) append_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
      6: repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: append_byte(CH_NL);
          1: append_byte(CH_CR);
          2: append_byte(CH_SP);
          default: append_byte(CH_TAB);
        endcase
      end
      7: begin
        append_byte(CH_SLASH);
        append_byte(CH_SLASH);
        repeat ($urandom_range(0, 6)) append_byte(word_char());
        if ($urandom_range(0, 4) != 0) append_byte(CH_NL);
      end
      8: begin
        append_byte(CH_SLASH);
        append_byte(CH_STAR);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: append_byte(CH_STAR);
            1: append_byte(CH_SLASH);
            2: append_byte(CH_NL);
            default: append_byte(word_char());
          endcase
        end
        // leave a few comments open
        if ($urandom_range(0, 5) != 0) begin
          repeat ($urandom_range(1, 3)) append_byte(CH_STAR);
          append_byte(CH_SLASH);
        end
      end
      9, 10: begin
        case ($urandom_range(0, 2))
          0: q = CH_DQ;
          1: q = CH_SQ;
          default: q = CH_BTICK;
        endcase
        append_byte(q);
        repeat ($urandom_range(0, 5)) begin
          b = $urandom_range(0, 1) ? word_char() : 8'($urandom_range(0, 255));
          append_byte(b == q ? CH_SP : b);
        end
        if ($urandom_range(0, 6) != 0) append_byte(q);
      end
      11: begin
        append_byte(CH_SLASH);
        append_byte(word_char());
      end
      12: append_byte(8'($urandom_range(0, 255)));
      13: append_byte(8'($urandom_range(127, 255)));
      default: append_byte(word_char());
    endcase
  endfunction

  initial begin
    int sent;
    int target;
    bit paused;
    sent = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed scripts: blank runs, CR, quotes, comment edge cases, byte extremes
    send_text("a \tb\r\n(", 1'b1);
    send_text("'q'/*/**/`s", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SP, 1'b1);
    send_text("y//", 1'b1);
    send_text("z\r", 1'b1);
    send_text("/*", 1'b1);

    while (sent < RANDOM_BYTES) begin
      src_calm = ($urandom_range(0, 4) == 0);
      text_q.delete();
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 25);
      while (text_q.size() < target) add_piece();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      sent += text_q.size();
      // hold off once until every result is back
      if (!paused && sent >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        src_valid <= 1'b0;
        while (waiting != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    src_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("script_text_minifier_tb OK");
    end else begin
      $display("script_text_minifier_tb NOT OK");
    end
    $finish;
  end

endmodule
